// ----- src/u8s_pkg.sv -----
// ----------------------------------------------------------------------------
// u8s_pkg
// types, constants and helper functions shared by the utf-8 sanitizer blocks
// ----------------------------------------------------------------------------
package u8s_pkg;

    localparam logic [7:0]  UNDERSCORE = 8'h5F;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] SUR_LO     = 21'h00D800;
    localparam logic [20:0] SUR_HI     = 21'h00DFFF;
    localparam logic [7:0]  LEAD_BAD   = 8'hF8;
    localparam int          JOB_BYTES  = 4;
    localparam int          QUEUE_DEPTH = 2;

    // output bytes caused by one input byte
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      stream_end;
    } t_job;

    // append up to n underscores, saturating at four bytes
    function automatic t_job fill_unders(t_job j, logic [2:0] n);
        t_job       r;
        logic [3:0] lim;
        r   = j;
        lim = {1'b0, j.count} + {1'b0, n};
        for (int i = 0; i < JOB_BYTES; i++) begin
            if (3'(i) >= j.count && 4'(i) < lim) begin
                r.bytes[i] = UNDERSCORE;
            end
        end
        r.count = (lim > 4'(JOB_BYTES)) ? 3'(JOB_BYTES) : lim[2:0];
        return r;
    endfunction

    function automatic t_job append_byte(t_job j, logic [7:0] b);
        t_job r;
        r = j;
        if (j.count < 3'(JOB_BYTES)) begin
            r.bytes[j.count[1:0]] = b;
            r.count = j.count + 3'd1;
        end
        return r;
    endfunction

    // shortest-form utf-8 encoding of a code point
    function automatic t_job encode_cp(logic [20:0] cp);
        t_job r;
        r = '0;
        if (cp < 21'h80) begin
            r.bytes[0] = cp[7:0];
            r.count    = 3'd1;
        end else if (cp < 21'h800) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.count    = 3'd2;
        end else if (cp < 21'h10000) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.count    = 3'd3;
        end else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.count    = 3'd4;
        end
        return r;
    endfunction

endpackage

// ----- src/u8s_in_if.sv -----
// ----------------------------------------------------------------------------
// u8s_in_if
// raw byte request channel into the sanitizer
// ----------------------------------------------------------------------------
interface u8s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_end;

    modport source (output valid, output in_byte, output in_end, input ready);
    modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

// ----- src/u8s_out_if.sv -----
// ----------------------------------------------------------------------------
// u8s_out_if
// sanitized byte request channel out of the sanitizer
// ----------------------------------------------------------------------------
interface u8s_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_run_last;
    logic       out_stream_end;

    modport source (output valid, output out_byte, output out_run_last,
                    output out_stream_end, input ready);
    modport sink   (input valid, input out_byte, input out_run_last,
                    input out_stream_end, output ready);
endinterface

// ----- src/utf8_sanitize_stream.sv -----
// ----------------------------------------------------------------------------
// utf8_sanitize_stream
// utf-8 decode and shortest-form re-encode with underscore replacement
// ----------------------------------------------------------------------------
// The block takes one raw byte per cycle on i_in while the job queue is not
// full and gives sanitized bytes on o_out, one per cycle while o_out.ready is
// high. Each input byte yields zero to four output bytes: complete sequences
// come out in shortest form, malformed input comes out as underscores, and
// out_run_last marks the last byte caused by one input byte. The input side is
// limited only by the two-entry job queue; the serializer sends each job's
// bytes in turn, and bytes that yield nothing (the lead and middle bytes of a
// sequence) push no job. An accepted byte's job is registered in the queue and
// then in the serializer's job register before its first output byte appears.
// ----------------------------------------------------------------------------
module utf8_sanitize_stream (
    input  logic      i_clk,
    input  logic      i_rst_n,
    u8s_in_if.sink    i_in,
    u8s_out_if.source o_out
);

    // front to queue
    logic          front_push;
    u8s_pkg::t_job front_job;

    // queue status and head
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    u8s_pkg::t_job q_job;

    // decoder: holds the open sequence and builds one job per input request
    u8s_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_byte  (i_in.in_byte),
        .i_end   (i_in.in_end),
        .i_full  (q_full),
        .o_ready (i_in.ready),
        .o_push  (front_push),
        .o_job   (front_job)
    );

    // decouples decoder from output backpressure
    u8s_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // serializer: walks through the bytes of each job
    u8s_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_job        (q_job),
        .i_ready      (o_out.ready),
        .o_pop        (q_pop),
        .o_valid      (o_out.valid),
        .o_byte       (o_out.out_byte),
        .o_run_last   (o_out.out_run_last),
        .o_stream_end (o_out.out_stream_end)
    );

`ifndef SYNTHESIS
    // an end-marked byte always produces at least one output byte
    a_end_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.in_end) |-> front_push)
        else $error("end byte produced no output job");

    // the stream end can only fall on the last byte of a run
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.out_stream_end) |-> o_out.out_run_last)
        else $error("stream end on a byte that is not last of its run");

    // nothing leaves the block in the cycle after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_out.valid)
        else $error("output valid right after reset");

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_push |-> !q_full)
        else $error("job queue overflow");
`endif

endmodule

// ----- src/u8s_front.sv -----
// ----------------------------------------------------------------------------
// u8s_front
// utf-8 decoder state and per-byte classification into output jobs
// ----------------------------------------------------------------------------
module u8s_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_end,
    input  logic          i_full,
    output logic          o_ready,
    output logic          o_push,
    output u8s_pkg::t_job o_job
);

    logic [20:0] r_acc, n_acc;
    logic [2:0]  r_len, n_len;
    logic [2:0]  r_seen, n_seen;

    logic          accept;
    logic          is_cont;
    logic          done;
    logic [20:0]   acc_next;
    logic [2:0]    seen_next;
    u8s_pkg::t_job job;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign is_cont = (i_byte[7:6] == 2'b10);
    assign acc_next  = {r_acc[14:0], i_byte[5:0]};
    assign seen_next = r_seen + 3'd1;

    always_comb begin
        job    = '0;
        n_acc  = r_acc;
        n_len  = r_len;
        n_seen = r_seen;
        done   = 1'b0;

        if (r_len != 3'd0) begin
            if (is_cont) begin
                done   = 1'b1;
                n_acc  = acc_next;
                n_seen = seen_next;
                if (seen_next >= r_len) begin
                    if (acc_next > u8s_pkg::CP_MAX ||
                        (acc_next >= u8s_pkg::SUR_LO && acc_next <= u8s_pkg::SUR_HI)) begin
                        job = u8s_pkg::fill_unders(job, r_len);
                    end else begin
                        job = u8s_pkg::encode_cp(acc_next);
                    end
                    n_acc  = '0;
                    n_len  = '0;
                    n_seen = '0;
                end
            end else begin
                // broken sequence, byte restarts below
                job    = u8s_pkg::fill_unders(job, r_seen);
                n_acc  = '0;
                n_len  = '0;
                n_seen = '0;
            end
        end

        if (!done) begin
            if (!i_byte[7]) begin
                job = u8s_pkg::append_byte(job, i_byte);
            end else if (is_cont || i_byte >= u8s_pkg::LEAD_BAD) begin
                job = u8s_pkg::append_byte(job, u8s_pkg::UNDERSCORE);
            end else begin
                n_seen = 3'd1;
                if (!i_byte[5]) begin
                    n_len = 3'd2;
                    n_acc = {16'd0, i_byte[4:0]};
                end else if (!i_byte[4]) begin
                    n_len = 3'd3;
                    n_acc = {17'd0, i_byte[3:0]};
                end else begin
                    n_len = 3'd4;
                    n_acc = {18'd0, i_byte[2:0]};
                end
            end
        end

        if (i_end) begin
            if (n_len != 3'd0) begin
                job = u8s_pkg::fill_unders(job, n_seen);
            end
            n_acc  = '0;
            n_len  = '0;
            n_seen = '0;
        end
        job.stream_end = i_end;
    end

    assign o_push = accept && (job.count != 3'd0);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_len  <= '0;
            r_seen <= '0;
        end else if (accept) begin
            r_acc  <= n_acc;
            r_len  <= n_len;
            r_seen <= n_seen;
        end
    end

endmodule

// ----- src/u8s_queue.sv -----
// ----------------------------------------------------------------------------
// u8s_queue
// short job queue between the decoder and the output serializer
// ----------------------------------------------------------------------------
module u8s_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  u8s_pkg::t_job i_job,
    input  logic          i_pop,
    output u8s_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PTR_W = $clog2(u8s_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(u8s_pkg::QUEUE_DEPTH + 1);

    u8s_pkg::t_job r_mem [u8s_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(u8s_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(u8s_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(u8s_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- src/u8s_back.sv -----
// ----------------------------------------------------------------------------
// u8s_back
// output serializer, one byte of the current job per request
// ----------------------------------------------------------------------------
module u8s_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  u8s_pkg::t_job i_job,
    input  logic          i_ready,
    output logic          o_pop,
    output logic          o_valid,
    output logic [7:0]    o_byte,
    output logic          o_run_last,
    output logic          o_stream_end
);

    logic          r_busy;
    logic [1:0]    r_idx;
    u8s_pkg::t_job r_job;
    logic          last;
    logic          take;

    assign last = ({1'b0, r_idx} + 3'd1) == r_job.count;
    assign take = r_busy && i_ready;
    assign o_pop = !i_empty && (!r_busy || (take && last));

    assign o_valid      = r_busy;
    assign o_byte       = r_job.bytes[r_idx];
    assign o_run_last   = last;
    assign o_stream_end = last && r_job.stream_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

endmodule
